[src/clns_pkg.sv]
// Shared types, codes and helpers for the character-LCD nibble sequencer.
package clns_pkg;

	// Input opcodes
	localparam logic [2:0] OP_INIT    = 3'd0;
	localparam logic [2:0] OP_INSTR   = 3'd1;
	localparam logic [2:0] OP_DATA    = 3'd2;
	localparam logic [2:0] OP_ADDR    = 3'd3;
	localparam logic [2:0] OP_CURSOR  = 3'd4;
	localparam logic [2:0] OP_DISPLAY = 3'd5;
	localparam logic [2:0] OP_REPLY   = 3'd6;

	// Job kinds passed from front to back
	localparam logic [1:0] KIND_CMD   = 2'd0;
	localparam logic [1:0] KIND_INIT  = 2'd1;
	localparam logic [1:0] KIND_REPLY = 2'd2;

	// Fixed bytes
	localparam logic [7:0] INIT_PORT   = 8'hFB;
	localparam logic [7:0] INIT_FIRST  = 8'h28;
	localparam logic [7:0] SET_ADDR    = 8'h80;
	localparam logic [7:0] ROW1_BASE   = 8'h40;
	localparam logic [7:0] ROW2_BASE   = 8'h14;
	localparam logic [7:0] ROW3_BASE   = 8'h54;
	localparam logic [3:0] DISP_CTRL   = 4'b1000;
	localparam logic [3:0] NIB_WAKE    = 4'h3;
	localparam logic [3:0] NIB_FOUR    = 4'h2;
	localparam logic [3:0] NIB_RELEASE = 4'hF;
	localparam logic [7:0] MAX_COLUMN  = 8'd19;
	localparam logic [7:0] MAX_ROW     = 8'd3;

	// One classified request
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;   // command byte, or reply byte for KIND_REPLY
		logic       rs;
	} job_t;

	// Data nibble, E, RW and RS replaced; BL kept
	function automatic logic [7:0] set_lines(input logic [7:0] sh, input logic [3:0] d,
		input logic e, input logic rw, input logic rs);
		return {d, sh[3], e, rw, rs};
	endfunction

	// E replaced, everything else kept
	function automatic logic [7:0] set_e(input logic [7:0] sh, input logic e);
		return {sh[7:3], e, sh[1:0]};
	endfunction

	// Fixed instruction list sent after the init wake-up
	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h28;
			3'd1: c = 8'h0C;
			3'd2: c = 8'h06;
			3'd3: c = 8'h02;
			default: c = 8'h01;
		endcase
		return c;
	endfunction

endpackage

[src/clns_front.sv]
// Front end: accepts requests and classifies them into jobs for the queue.
module clns_front (
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    opcode,
	input  logic [7:0]    value,
	input  logic [7:0]    column,
	input  logic [7:0]    row,
	input  logic          cursor_on,
	input  logic          blink_on,
	input  logic          display_on,
	input  logic [7:0]    read_byte,
	output logic          push_valid,
	input  logic          push_ready,
	output clns_pkg::job_t push_job
);
	import clns_pkg::*;

	logic       keep;
	logic [7:0] base;
	logic [7:0] cur_addr;

	// Row base address
	always_comb begin
		case (row[1:0])
			2'd0: base = 8'h00;
			2'd1: base = ROW1_BASE;
			2'd2: base = ROW2_BASE;
			default: base = ROW3_BASE;
		endcase
	end

	assign cur_addr = (base + column) | SET_ADDR;

	// Classify; requests that can never cause output are dropped here
	always_comb begin
		keep = 1'b1;
		push_job.kind = KIND_CMD;
		push_job.data = value;
		push_job.rs = 1'b0;
		case (opcode)
			OP_INIT: push_job.kind = KIND_INIT;
			OP_INSTR: push_job.data = value;
			OP_DATA: push_job.rs = 1'b1;
			OP_ADDR: push_job.data = value | SET_ADDR;
			OP_CURSOR: begin
				push_job.data = cur_addr;
				keep = (row <= MAX_ROW) && (column <= MAX_COLUMN);
			end
			OP_DISPLAY: push_job.data = {4'h0, DISP_CTRL} |
				{5'd0, display_on, cursor_on, blink_on};
			OP_REPLY: begin
				push_job.kind = KIND_REPLY;
				push_job.data = read_byte;
			end
			default: keep = 1'b0;
		endcase
	end

	assign in_ready   = push_ready;
	assign push_valid = in_valid && keep;

endmodule

[src/clns_queue.sv]
// Short job queue between front and back ends.
module clns_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  clns_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output clns_pkg::job_t pop_job
);
	import clns_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/clns_back.sv]
// Back end: steps each job through its port accesses, one per cycle unless out_ready holds the output.
module clns_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  clns_pkg::job_t job,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     port_byte,
	output logic           is_read,
	output logic           command_done,
	output logic           last
);
	import clns_pkg::*;

	// Sequencer steps
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_I0   = 5'd1;
	localparam logic [4:0] ST_I1   = 5'd2;
	localparam logic [4:0] ST_I2   = 5'd3;
	localparam logic [4:0] ST_I3   = 5'd4;
	localparam logic [4:0] ST_I4   = 5'd5;
	localparam logic [4:0] ST_I5   = 5'd6;
	localparam logic [4:0] ST_I6   = 5'd7;
	localparam logic [4:0] ST_B0   = 5'd8;
	localparam logic [4:0] ST_E1   = 5'd9;
	localparam logic [4:0] ST_RD   = 5'd10;
	localparam logic [4:0] ST_R0   = 5'd11;
	localparam logic [4:0] ST_F0   = 5'd12;
	localparam logic [4:0] ST_F1   = 5'd13;
	localparam logic [4:0] ST_F2   = 5'd14;
	localparam logic [4:0] ST_F3   = 5'd15;

	// Busy-poll phase
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	logic [4:0] st_q;
	logic [4:0] st_nxt;
	logic [1:0] phase_q;
	logic [7:0] port_shadow_q;
	logic [7:0] pending_q;
	logic       pending_rs_q;
	logic       busy_seen_q;
	logic [2:0] init_step_q;
	logic [7:0] reply_q;
	logic       out_valid_q;
	logic [7:0] port_byte_q;
	logic       is_read_q;
	logic       done_q;
	logic       last_q;

	logic       step_en;
	logic       take;
	logic       more;
	logic [7:0] sh_nxt;
	logic       rd_nxt;
	logic       done_nxt;
	logic       last_nxt;

	assign job_ready = (st_q == ST_IDLE);
	assign take      = job_valid && job_ready;
	assign step_en   = (st_q != ST_IDLE) && (!out_valid_q || out_ready);
	assign more      = (init_step_q inside {[3'd1:3'd4]});

	// Port value and next step of the current access
	always_comb begin
		sh_nxt   = port_shadow_q;
		rd_nxt   = 1'b0;
		done_nxt = 1'b0;
		last_nxt = 1'b0;
		st_nxt   = st_q;
		case (st_q)
			ST_I0: begin
				sh_nxt = INIT_PORT;
				st_nxt = ST_I1;
			end
			ST_I1, ST_I3: begin
				sh_nxt = set_lines(port_shadow_q, NIB_WAKE, 1'b1, 1'b0, 1'b0);
				st_nxt = st_q + 5'd1;
			end
			ST_I5: begin
				sh_nxt = set_lines(port_shadow_q, NIB_FOUR, 1'b1, 1'b0, 1'b0);
				st_nxt = ST_I6;
			end
			ST_I2, ST_I4: begin
				sh_nxt = set_e(port_shadow_q, 1'b0);
				st_nxt = st_q + 5'd1;
			end
			ST_I6: begin
				sh_nxt = set_e(port_shadow_q, 1'b0);
				st_nxt = ST_B0;
			end
			ST_B0: begin
				sh_nxt = set_lines(port_shadow_q, NIB_RELEASE, 1'b0, 1'b1, 1'b0);
				st_nxt = ST_E1;
			end
			ST_E1: begin
				sh_nxt = set_e(port_shadow_q, 1'b1);
				st_nxt = ST_RD;
			end
			ST_RD: begin
				rd_nxt   = 1'b1;
				last_nxt = 1'b1;
				st_nxt   = ST_IDLE;
			end
			ST_R0: begin
				// reply replaces the shadow, then data 1111, E low, BL high
				sh_nxt = {NIB_RELEASE, 1'b1, 1'b0, reply_q[1:0]};
				st_nxt = (phase_q == PH_FIRST || busy_seen_q) ? ST_E1 : ST_F0;
			end
			ST_F0: begin
				sh_nxt = set_lines(port_shadow_q, pending_q[7:4], 1'b1, 1'b0, pending_rs_q);
				st_nxt = ST_F1;
			end
			ST_F2: begin
				sh_nxt = set_lines(port_shadow_q, pending_q[3:0], 1'b1, 1'b0, pending_rs_q);
				st_nxt = ST_F3;
			end
			ST_F1: begin
				sh_nxt = set_e(port_shadow_q, 1'b0);
				st_nxt = ST_F2;
			end
			ST_F3: begin
				sh_nxt   = set_e(port_shadow_q, 1'b0);
				done_nxt = !more;
				last_nxt = !more;
				st_nxt   = more ? ST_B0 : ST_IDLE;
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			phase_q       <= PH_IDLE;
			port_shadow_q <= '0;
			pending_rs_q  <= 1'b0;
			busy_seen_q   <= 1'b0;
			init_step_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				case (job.kind)
					KIND_REPLY: begin
						if (phase_q != PH_IDLE) begin
							st_q <= ST_R0;
						end
					end
					KIND_INIT: begin
						if (phase_q == PH_IDLE) begin
							st_q         <= ST_I0;
							init_step_q  <= 3'd1;
							pending_rs_q <= 1'b0;
						end
					end
					default: begin
						if (phase_q == PH_IDLE) begin
							st_q         <= ST_B0;
							pending_rs_q <= job.rs;
						end
					end
				endcase
			end
			if (step_en) begin
				st_q          <= st_nxt;
				port_shadow_q <= sh_nxt;
				out_valid_q   <= 1'b1;
				if (st_q == ST_R0 && phase_q == PH_FIRST) begin
					busy_seen_q <= reply_q[7];
				end
				if (st_q == ST_RD) begin
					phase_q <= (phase_q == PH_FIRST) ? PH_SECOND : PH_FIRST;
				end
				if (st_q == ST_F3) begin
					phase_q      <= PH_IDLE;
					pending_rs_q <= 1'b0;
					init_step_q  <= more ? init_step_q + 3'd1 : 3'd0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers; a command arriving mid-poll leaves the pending byte alone
	always_ff @(posedge clk) begin
		if (take) begin
			reply_q <= job.data;
			if (phase_q == PH_IDLE) begin
				if (job.kind == KIND_INIT) begin
					pending_q <= INIT_FIRST;
				end else if (job.kind == KIND_CMD) begin
					pending_q <= job.data;
				end
			end
		end
		if (step_en) begin
			port_byte_q <= sh_nxt;
			is_read_q   <= rd_nxt;
			done_q      <= done_nxt;
			last_q      <= last_nxt;
			if (st_q == ST_F3 && more) begin
				pending_q <= init_cmd(init_step_q);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign port_byte    = port_byte_q;
	assign is_read      = is_read_q;
	assign command_done = done_q;
	assign last         = last_q;

endmodule

[src/char_lcd_nibble_sequencer_top.sv]
// Top level of the character-LCD nibble sequencer.
// Turns character-LCD requests into 4-bit expander port accesses (D7-D4, BL, E, RW, RS).
// A request is taken whenever the job queue (QUEUE_DEPTH entries) has room,
// also while results are still going out. The back-end sequencer takes each job
// while idle, then issues one port access per cycle while out_ready is high:
// a command gives 3 accesses ending in a busy-poll read, a read reply 3, 5 or 8,
// and init 10; a command or init taken mid-poll, or a reply with no poll pending,
// gives none; an unused opcode or an off-screen cursor is dropped in the front end.
// Read replies must be fed back as requests with opcode 6.
module char_lcd_nibble_sequencer_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] opcode,
	input  logic [7:0] value,
	input  logic [7:0] column,
	input  logic [7:0] row,
	input  logic       cursor_on,
	input  logic       blink_on,
	input  logic       display_on,
	input  logic [7:0] read_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] port_byte,
	output logic       is_read,
	output logic       command_done,
	output logic       last
);
	import clns_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	// Request classification
	clns_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.value      (value),
		.column     (column),
		.row        (row),
		.cursor_on  (cursor_on),
		.blink_on   (blink_on),
		.display_on (display_on),
		.read_byte  (read_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// Job queue
	clns_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// Port access sequencer
	clns_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (pop_valid),
		.job_ready    (pop_ready),
		.job          (pop_job),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.port_byte    (port_byte),
		.is_read      (is_read),
		.command_done (command_done),
		.last         (last)
	);

endmodule
